// ----- rtl/scl_pkg.sv -----
// Shared types, constants and helper functions of the shell command lexer.
// Used by every module of the block; depends on nothing else.
package scl_pkg;

    localparam int LINE_MAX_LEN = 4096;
    localparam int POS_W        = $clog2(LINE_MAX_LEN);
    localparam int OUT_W        = 12;
    localparam int OUT_MAX      = (1 << OUT_W) - 1;
    localparam int CLAMP_W      = (POS_W > OUT_W) ? POS_W : OUT_W;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 32;

    // Byte values that the lexer treats specially.
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_PIPE   = 8'h7C;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;

    // Operator bytes that may pair with an identical follower.
    localparam logic [1:0] OP_LT   = 2'd0;
    localparam logic [1:0] OP_GT   = 2'd1;
    localparam logic [1:0] OP_PIPE = 2'd2;
    localparam logic [1:0] OP_AMP  = 2'd3;

    localparam logic [1:0] QUOTE_NONE   = 2'd0;
    localparam logic [1:0] QUOTE_SINGLE = 2'd1;
    localparam logic [1:0] QUOTE_DOUBLE = 2'd2;

    typedef enum logic [3:0] {
        KIND_WORD      = 4'd0,
        KIND_PIPE      = 4'd1,
        KIND_OR        = 4'd2,
        KIND_AND       = 4'd3,
        KIND_AMP       = 4'd4,
        KIND_REDIR_IN  = 4'd5,
        KIND_REDIR_OUT = 4'd6,
        KIND_HEREDOC   = 4'd7,
        KIND_APPEND    = 4'd8,
        KIND_LPAREN    = 4'd9,
        KIND_RPAREN    = 4'd10,
        KIND_EOF       = 4'd11
    } kind_t;

    typedef enum logic [2:0] {
        MODE_IDLE = 3'b001,
        MODE_WORD = 3'b010,
        MODE_HELD = 3'b100
    } mode_t;

    // One classified input beat as it travels from the front to the back.
    typedef struct packed {
        logic             eol;
        logic             space;
        logic             lparen;
        logic             rparen;
        logic             op_valid;
        logic [1:0]       op_idx;
        logic [1:0]       quote;
        logic [POS_W-1:0] pos;
    } item_t;

    typedef struct packed {
        kind_t            kind;
        logic [OUT_W-1:0] start;
        logic [OUT_W-1:0] len;
        logic             unclosed;
        logic             last;
    } result_t;

    function automatic logic [OUT_W-1:0] clamp_out(input logic [POS_W-1:0] v);
        logic [CLAMP_W-1:0] w;
        w = CLAMP_W'(v);
        if (w > CLAMP_W'(OUT_MAX))
            return OUT_W'(OUT_MAX);
        else
            return w[OUT_W-1:0];
    endfunction

    function automatic kind_t single_kind(input logic [1:0] idx);
        case (idx)
            OP_LT:   return KIND_REDIR_IN;
            OP_GT:   return KIND_REDIR_OUT;
            OP_PIPE: return KIND_PIPE;
            default: return KIND_AMP;
        endcase
    endfunction

    function automatic kind_t double_kind(input logic [1:0] idx);
        case (idx)
            OP_LT:   return KIND_HEREDOC;
            OP_GT:   return KIND_APPEND;
            OP_PIPE: return KIND_OR;
            default: return KIND_AND;
        endcase
    endfunction

    function automatic result_t make_result(input kind_t kind,
                                            input logic [POS_W-1:0] start,
                                            input logic [POS_W-1:0] len,
                                            input logic unclosed,
                                            input logic last);
        result_t r;
        r.kind     = kind;
        r.start    = clamp_out(start);
        r.len      = clamp_out(len);
        r.unclosed = unclosed;
        r.last     = last;
        return r;
    endfunction

endpackage

// ----- rtl/scl_front.sv -----
// Front end of the shell command lexer: accepts input beats, classifies each
// byte and tags it with its saturating line position. Depends on scl_pkg.
module scl_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic [7:0]     s_tdata,   // char_code
    input  logic           s_tlast,   // end_of_line
    output logic           item_valid,
    input  logic           item_ready,
    output scl_pkg::item_t item
);
    import scl_pkg::*;

    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic             accept;

    assign s_tready   = item_ready;
    assign item_valid = s_tvalid;
    assign accept     = s_tvalid && s_tready;

    always_comb
    begin
        item          = '0;
        item.eol      = s_tlast;
        item.pos      = pos_reg;
        item.space    = s_tdata inside {CH_SPACE, [CH_TAB:CH_CR]};
        item.lparen   = (s_tdata == CH_LPAREN);
        item.rparen   = (s_tdata == CH_RPAREN);
        item.op_valid = 1'b1;
        case (s_tdata)
            CH_LT:   item.op_idx = OP_LT;
            CH_GT:   item.op_idx = OP_GT;
            CH_PIPE: item.op_idx = OP_PIPE;
            CH_AMP:  item.op_idx = OP_AMP;
            default:
            begin
                item.op_valid = 1'b0;
                item.op_idx   = OP_LT;
            end
        endcase
        case (s_tdata)
            CH_SQUOTE: item.quote = QUOTE_SINGLE;
            CH_DQUOTE: item.quote = QUOTE_DOUBLE;
            default:   item.quote = QUOTE_NONE;
        endcase
    end

    // Position saturates at the last offset of a line and restarts after end of line.
    always_comb
    begin
        pos_next = pos_reg;
        if (accept)
        begin
            if (s_tlast)
                pos_next = '0;
            else if (pos_reg != POS_W'(LINE_MAX_LEN - 1))
                pos_next = pos_reg + POS_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pos_reg <= '0;
        else
            pos_reg <= pos_next;
    end

endmodule

// ----- rtl/scl_fifo.sv -----
// Short queue of classified beats between the lexer front and back ends.
// Depends on scl_pkg for the entry type and depth.
module scl_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  scl_pkg::item_t in_item,
    output logic           out_valid,
    input  logic           out_ready,
    output scl_pkg::item_t out_item
);
    import scl_pkg::*;

    item_t              entry_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg;
    logic [FIFO_AW-1:0] rd_ptr_reg;
    logic [FIFO_AW:0]   cnt_reg;
    logic               push;
    logic               pop;

    assign in_ready  = (cnt_reg != (FIFO_AW + 1)'(FIFO_DEPTH));
    assign out_valid = (cnt_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_item  = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= in_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + FIFO_AW'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + FIFO_AW'(1);
            cnt_reg <= cnt_reg + (FIFO_AW + 1)'(push) - (FIFO_AW + 1)'(pop);
        end
    end

endmodule

// ----- rtl/scl_back.sv -----
// Back end of the shell command lexer: runs the token state machine on each
// queued beat and buffers up to two results for the output. Depends on scl_pkg.
module scl_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           item_valid,
    output logic           item_ready,
    input  scl_pkg::item_t item,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [31:0]    m_tdata,   // token_kind, start_pos, token_len, zero pad
    output logic           m_tlast,   // last_of_line
    output logic           m_tuser    // unclosed_quote
);
    import scl_pkg::*;

    mode_t            mode_reg, mode_next;
    logic [1:0]       quote_reg, quote_next;
    logic [1:0]       held_reg, held_next;
    logic [POS_W-1:0] ws_reg, ws_next;

    result_t          slot_reg [2];
    logic             rd_reg;
    logic             wr_reg;
    logic [1:0]       cnt_reg;

    result_t          res0, res1, paren;
    logic [1:0]       n;
    logic [1:0]       free;
    logic             do_begin;
    logic             consume;
    logic             out_pop;
    logic [POS_W-1:0] word_len;
    result_t          cur;

    assign word_len = item.pos - ws_reg;

    always_comb
    begin
        res0       = '0;
        res1       = '0;
        paren      = '0;
        n          = 2'd0;
        do_begin   = 1'b0;
        mode_next  = mode_reg;
        quote_next = quote_reg;
        held_next  = held_reg;
        ws_next    = ws_reg;
        if (item.eol)
        begin
            case (mode_reg)
                MODE_HELD:
                begin
                    res0 = make_result(single_kind(held_reg), ws_reg, POS_W'(1), 1'b0, 1'b0);
                    res1 = make_result(KIND_EOF, item.pos, '0, 1'b0, 1'b1);
                    n    = 2'd2;
                end
                MODE_WORD:
                begin
                    if (quote_reg != QUOTE_NONE)
                    begin
                        res0 = make_result(KIND_WORD, ws_reg, word_len, 1'b1, 1'b1);
                        n    = 2'd1;
                    end
                    else
                    begin
                        res0 = make_result(KIND_WORD, ws_reg, word_len, 1'b0, 1'b0);
                        res1 = make_result(KIND_EOF, item.pos, '0, 1'b0, 1'b1);
                        n    = 2'd2;
                    end
                end
                default:
                begin
                    res0 = make_result(KIND_EOF, item.pos, '0, 1'b0, 1'b1);
                    n    = 2'd1;
                end
            endcase
            mode_next  = MODE_IDLE;
            quote_next = QUOTE_NONE;
            held_next  = OP_LT;
            ws_next    = '0;
        end
        else
        begin
            case (mode_reg)
                MODE_HELD:
                begin
                    if (item.op_valid && (item.op_idx == held_reg))
                    begin
                        res0      = make_result(double_kind(held_reg), ws_reg, POS_W'(2),
                                                1'b0, 1'b0);
                        n         = 2'd1;
                        mode_next = MODE_IDLE;
                    end
                    else
                    begin
                        res0     = make_result(single_kind(held_reg), ws_reg, POS_W'(1),
                                               1'b0, 1'b0);
                        n        = 2'd1;
                        do_begin = 1'b1;
                    end
                end
                MODE_WORD:
                begin
                    if (quote_reg != QUOTE_NONE)
                    begin
                        if (item.quote == quote_reg)
                            quote_next = QUOTE_NONE;
                    end
                    else if (item.space || item.lparen || item.rparen || item.op_valid)
                    begin
                        res0     = make_result(KIND_WORD, ws_reg, word_len, 1'b0, 1'b0);
                        n        = 2'd1;
                        do_begin = 1'b1;
                    end
                    else
                    begin
                        quote_next = item.quote;
                    end
                end
                default:
                begin
                    do_begin = 1'b1;
                end
            endcase

            // Start of a new token, after any token that this beat closed.
            if (do_begin)
            begin
                mode_next = MODE_IDLE;
                if (item.space)
                begin
                    mode_next = MODE_IDLE;
                end
                else if (item.lparen || item.rparen)
                begin
                    paren = make_result(item.lparen ? KIND_LPAREN : KIND_RPAREN, item.pos,
                                        POS_W'(1), 1'b0, 1'b0);
                    if (n == 2'd0)
                        res0 = paren;
                    else
                        res1 = paren;
                    n = n + 2'd1;
                end
                else if (item.op_valid)
                begin
                    mode_next = MODE_HELD;
                    held_next = item.op_idx;
                    ws_next   = item.pos;
                end
                else
                begin
                    mode_next  = MODE_WORD;
                    ws_next    = item.pos;
                    quote_next = item.quote;
                end
            end
        end
    end

    // A beat is taken only when all of its results fit in the output buffer.
    assign out_pop    = m_tvalid && m_tready;
    assign free       = 2'd2 - cnt_reg + {1'b0, out_pop};
    assign item_ready = (n <= free);
    assign consume    = item_valid && item_ready;

    assign m_tvalid = (cnt_reg != 2'd0);
    assign cur      = slot_reg[rd_reg];
    assign m_tdata  = {4'b0, cur.len, cur.start, cur.kind};
    assign m_tlast  = cur.last;
    assign m_tuser  = cur.unclosed;

    always_ff @(posedge clk)
    begin
        if (consume && (n != 2'd0))
            slot_reg[wr_reg] <= res0;
        if (consume && (n == 2'd2))
            slot_reg[~wr_reg] <= res1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            quote_reg <= QUOTE_NONE;
            held_reg  <= OP_LT;
            ws_reg    <= '0;
            rd_reg    <= 1'b0;
            wr_reg    <= 1'b0;
            cnt_reg   <= 2'd0;
        end
        else
        begin
            if (consume)
            begin
                mode_reg  <= mode_next;
                quote_reg <= quote_next;
                held_reg  <= held_next;
                ws_reg    <= ws_next;
                wr_reg    <= wr_reg ^ n[0];
            end
            if (out_pop)
                rd_reg <= ~rd_reg;
            cnt_reg <= cnt_reg - {1'b0, out_pop} + (consume ? n : 2'd0);
        end
    end

endmodule

// ----- rtl/shell_command_lexer.sv -----
// Shell command line lexer: one byte per beat in, one token per beat out.
// The byte that ends a token passes the queue, and its token the result buffer.
// Throughput: one byte per cycle while the queue has room; a byte that closes two
// tokens waits for room; the four-entry queue behind the classifier absorbs the wait.
// Reset clears the lexer state, the line position and all queues; no beat is held.
// Depends on scl_pkg, scl_front, scl_fifo and scl_back.
module shell_command_lexer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // char_code
    input  logic        s_tlast,   // end_of_line
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // token_kind, start_pos, token_len, zero pad
    output logic        m_tlast,   // last_of_line
    output logic        m_tuser    // unclosed_quote
);
    import scl_pkg::*;

    item_t front_item;
    item_t head_item;
    logic  front_valid;
    logic  front_ready;
    logic  head_valid;
    logic  head_ready;

    scl_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .item_valid (front_valid),
        .item_ready (front_ready),
        .item       (front_item)
    );

    scl_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_item   (front_item),
        .out_valid (head_valid),
        .out_ready (head_ready),
        .out_item  (head_item)
    );

    scl_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (head_valid),
        .item_ready (head_ready),
        .item       (head_item),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser)
    );

endmodule
